@@ src/clsc_pkg.sv @@
// Shared constants and types of the coherent line store controller.
package clsc_pkg;

  // Store geometry (the address width follows from the line count)
  localparam int NumLines  = 256;
  localparam int AddrWidth = $clog2(NumLines);
  localparam int DataWidth = 32;

  // Request codes
  localparam logic [2:0] REQ_CPU_READ   = 3'd0;
  localparam logic [2:0] REQ_CPU_WRITE  = 3'd1;
  localparam logic [2:0] REQ_MEM_DONE   = 3'd2;
  localparam logic [2:0] REQ_SNOOP_INV  = 3'd3;
  localparam logic [2:0] REQ_SNOOP_SHR  = 3'd4;

  // Coherence marks
  localparam logic [1:0] MARK_INVALID = 2'd0;
  localparam logic [1:0] MARK_SHARED  = 2'd1;
  localparam logic [1:0] MARK_PRIVATE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic lookup;  // read the line mark and word
    logic commit;  // apply the update and load the output register
  } clsc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;  // output register holds an untaken result
  } clsc_status_t;

endpackage

@@ src/clsc_ctrl.sv @@
// Control state machine: accept, lookup, update.
module clsc_ctrl
  import clsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_ready,
  input  clsc_status_t status,
  output clsc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Output register can take a result this cycle
  assign out_free = !status.out_full || out_ready;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.lookup = (state == S_LOOKUP);
  assign cmd.commit = (state == S_UPDATE) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/clsc_datapath.sv @@
// Line store, pending-operation registers and output register.
module clsc_datapath
  import clsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  clsc_cmd_t            cmd,
  output clsc_status_t         status,
  input  logic [2:0]           req_type,
  input  logic [AddrWidth-1:0] line_address,
  input  logic [DataWidth-1:0] data_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DataWidth-1:0] read_data,
  output logic                 read_valid,
  output logic                 mem_read_req,
  output logic                 mem_write_req,
  output logic [AddrWidth-1:0] mem_address,
  output logic [DataWidth-1:0] mem_write_data,
  output logic                 write_done,
  output logic                 rejected,
  output logic [1:0]           line_mark
);

  // Captured transaction
  logic [2:0]           kind;
  logic [AddrWidth-1:0] addr;
  logic [DataWidth-1:0] word;

  // Pending memory operation
  logic                 busy;
  logic                 pending_is_write;
  logic [AddrWidth-1:0] pending_address;
  logic [DataWidth-1:0] pending_write_word;

  // Line store: marks and words in memories, valid bits in flops
  logic [1:0]           mark_mem [NumLines];
  logic [DataWidth-1:0] word_mem [NumLines];
  logic [NumLines-1:0]  mark_vld;

  // Lookup results
  logic [AddrWidth-1:0] look_addr;
  logic [1:0]           mark_raw;
  logic                 mark_raw_vld;
  logic [DataWidth-1:0] look_word;
  logic [AddrWidth-1:0] rd_addr;
  logic [1:0]           mark_cur;

  // Update logic
  logic                 mark_we;
  logic [1:0]           mark_wdata;
  logic                 word_we;
  logic [DataWidth-1:0] word_wdata;
  logic                 busy_next;
  logic                 pend_load;
  logic [DataWidth-1:0] res_read_data;
  logic                 res_read_valid;
  logic                 res_mem_read_req;
  logic                 res_mem_write_req;
  logic [AddrWidth-1:0] res_mem_address;
  logic [DataWidth-1:0] res_mem_write_data;
  logic                 res_write_done;
  logic                 res_rejected;

  assign status.out_full = out_valid;

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      addr <= line_address;
      word <= data_word;
    end
  end

  // A completing memory done addresses the pending line
  assign rd_addr = (kind == REQ_MEM_DONE && busy) ? pending_address : addr;

  // Store read, registered
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      look_addr    <= rd_addr;
      mark_raw     <= mark_mem[rd_addr];
      mark_raw_vld <= mark_vld[rd_addr];
      look_word    <= word_mem[rd_addr];
    end
  end

  assign mark_cur = mark_raw_vld ? mark_raw : MARK_INVALID;

  // Transaction decode and result
  always_comb begin
    mark_we            = 1'b0;
    mark_wdata         = mark_cur;
    word_we            = 1'b0;
    word_wdata         = word;
    busy_next          = busy;
    pend_load          = 1'b0;
    res_read_data      = '0;
    res_read_valid     = 1'b0;
    res_mem_read_req   = 1'b0;
    res_mem_write_req  = 1'b0;
    res_mem_address    = '0;
    res_mem_write_data = '0;
    res_write_done     = 1'b0;
    res_rejected       = 1'b0;
    unique case (kind)
      REQ_CPU_READ: begin
        if (busy) begin
          res_rejected = 1'b1;
        end else if (mark_cur == MARK_INVALID) begin
          busy_next        = 1'b1;
          pend_load        = 1'b1;
          res_mem_read_req = 1'b1;
          res_mem_address  = addr;
        end else begin
          res_read_data  = look_word;
          res_read_valid = 1'b1;
        end
      end
      REQ_CPU_WRITE: begin
        if (busy) begin
          res_rejected = 1'b1;
        end else begin
          busy_next          = 1'b1;
          pend_load          = 1'b1;
          res_mem_write_req  = 1'b1;
          res_mem_address    = addr;
          res_mem_write_data = word;
        end
      end
      REQ_MEM_DONE: begin
        if (busy) begin
          busy_next = 1'b0;
          mark_we   = 1'b1;
          word_we   = 1'b1;
          if (pending_is_write) begin
            mark_wdata     = MARK_PRIVATE;
            word_wdata     = pending_write_word;
            res_write_done = 1'b1;
          end else begin
            mark_wdata     = MARK_SHARED;
            word_wdata     = word;
            res_read_data  = word;
            res_read_valid = 1'b1;
          end
        end
      end
      REQ_SNOOP_INV: begin
        mark_we    = 1'b1;
        mark_wdata = MARK_INVALID;
      end
      REQ_SNOOP_SHR: begin
        if (mark_cur == MARK_PRIVATE) begin
          mark_we    = 1'b1;
          mark_wdata = MARK_SHARED;
        end
      end
      default: begin
      end
    endcase
  end

  // Store write
  always_ff @(posedge clk) begin
    if (cmd.commit && mark_we) mark_mem[look_addr] <= mark_wdata;
    if (cmd.commit && word_we) word_mem[look_addr] <= word_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_vld <= '0;
    end else if (cmd.commit && mark_we) begin
      mark_vld[look_addr] <= 1'b1;
    end
  end

  // Pending operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b0;
      pending_is_write   <= 1'b0;
      pending_address    <= '0;
      pending_write_word <= '0;
    end else if (cmd.commit) begin
      busy <= busy_next;
      if (pend_load) begin
        pending_is_write <= (kind == REQ_CPU_WRITE);
        pending_address  <= addr;
        if (kind == REQ_CPU_WRITE) pending_write_word <= word;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data      <= res_read_data;
      read_valid     <= res_read_valid;
      mem_read_req   <= res_mem_read_req;
      mem_write_req  <= res_mem_write_req;
      mem_address    <= res_mem_address;
      mem_write_data <= res_mem_write_data;
      write_done     <= res_write_done;
      rejected       <= res_rejected;
      line_mark      <= mark_wdata;
    end
  end

endmodule

@@ src/coherent_line_store_controller.sv @@
// Top level of the coherent line store controller.
//
// A direct-indexed store of 256 words with an invalid/shared/private mark
// per line. Each input transaction (cpu read, cpu write, memory done, snoop
// invalidate, snoop share) yields exactly one result transaction. A
// transaction goes through capture, a registered read of the line mark and
// word memories, then the update and load of the output register; these
// steps follow the single-port lookup-then-write of the line store. A
// new transaction is taken while the previous result still waits in the
// output register; the update stalls only when that register is still
// full and not taken. Line marks come out of reset invalid through
// per-line valid bits, so no clearing pass is needed.
module coherent_line_store_controller
  import clsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           req_type,
  input  logic [AddrWidth-1:0] line_address,
  input  logic [DataWidth-1:0] data_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DataWidth-1:0] read_data,
  output logic                 read_valid,
  output logic                 mem_read_req,
  output logic                 mem_write_req,
  output logic [AddrWidth-1:0] mem_address,
  output logic [DataWidth-1:0] mem_write_data,
  output logic                 write_done,
  output logic                 rejected,
  output logic [1:0]           line_mark
);

  clsc_cmd_t    cmd;
  clsc_status_t status;

  clsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .line_address   (line_address),
    .data_word      (data_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .mem_read_req   (mem_read_req),
    .mem_write_req  (mem_write_req),
    .mem_address    (mem_address),
    .mem_write_data (mem_write_data),
    .write_done     (write_done),
    .rejected       (rejected),
    .line_mark      (line_mark)
  );

endmodule
